FILE: design/nsmd_pkg.sv
package nsmd_pkg;

	// Capacity of the element store.
	localparam int MAX_ITEMS = 1024;

	localparam int VALUE_W = 31;
	localparam int ELEM_W  = 11;
	localparam int ADDR_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int DEPTH_W = $clog2(MAX_ITEMS + 2);
	// Stack entries including the sentinel at the bottom.
	localparam int STACK_ENTRIES = MAX_ITEMS + 1;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCMP,
		ST_RSTART,
		ST_RLOAD,
		ST_RCMP,
		ST_RMAX,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		STK_NOP,
		STK_PUSH,
		STK_POP,
		STK_CLEAR
	} stk_op_t;

	typedef struct packed {
		stk_op_t op;
		value_t  data;
	} stk_cmd_t;

	typedef struct packed {
		value_t top;
		logic   at_base;
		depth_t depth;
	} stk_status_t;

endpackage

FILE: design/nsmd_in_if.sv
interface nsmd_in_if;
	import nsmd_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	logic   last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: design/nsmd_out_if.sv
interface nsmd_out_if;
	import nsmd_pkg::*;

	logic              valid;
	logic              ready;
	value_t            max_difference;
	logic [ELEM_W-1:0] element_count;
	logic              overflow;

	modport source (output valid, output max_difference, output element_count,
		output overflow, input ready);
	modport sink   (input valid, input max_difference, input element_count,
		input overflow, output ready);
endinterface

FILE: design/nsmd_stack.sv
module nsmd_stack (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nsmd_pkg::stk_cmd_t    cmd,
	output nsmd_pkg::stk_status_t status
);
	import nsmd_pkg::*;

	// Entry k of the stack (k >= 1) lives at address k - 1; the sentinel is implicit.
	value_t stack_mem [MAX_ITEMS];

	depth_t depth_q;
	value_t top_q;
	value_t rd_q;
	logic   pend_q;

	logic   mem_we;
	logic   mem_re;
	addr_t  wr_addr;
	addr_t  rd_addr;

	assign mem_we  = (cmd.op == STK_PUSH);
	assign mem_re  = (cmd.op == STK_POP) && (depth_q > DEPTH_W'(2));
	assign wr_addr = ADDR_W'(depth_q - DEPTH_W'(1));
	assign rd_addr = ADDR_W'(depth_q - DEPTH_W'(3));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[wr_addr] <= cmd.data;
		end
		if (mem_re) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_W'(1);
			pend_q  <= 1'b0;
		end else begin
			unique case (cmd.op)
				STK_PUSH: begin
					depth_q <= depth_q + DEPTH_W'(1);
					pend_q  <= 1'b0;
				end
				STK_POP: begin
					depth_q <= depth_q - DEPTH_W'(1);
					pend_q  <= mem_re;
				end
				STK_CLEAR: begin
					depth_q <= DEPTH_W'(1);
					pend_q  <= 1'b0;
				end
				STK_NOP: begin
					pend_q <= 1'b0;
				end
				default: begin
					pend_q <= 1'b0;
				end
			endcase
		end
	end

	// The top is cached; after a pop the freshly read entry is forwarded while it is written into the cache.
	always_ff @(posedge clk) begin
		if (cmd.op == STK_PUSH) begin
			top_q <= cmd.data;
		end else if (pend_q) begin
			top_q <= rd_q;
		end
	end

	always_comb begin
		status.depth   = depth_q;
		status.at_base = (depth_q == DEPTH_W'(1));
		if (depth_q == DEPTH_W'(1)) begin
			status.top = '0;
		end else if (pend_q) begin
			status.top = rd_q;
		end else begin
			status.top = top_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == STK_POP) |-> (depth_q > DEPTH_W'(1)))
		else $error("stack popped past the sentinel");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == STK_PUSH) |-> (depth_q < DEPTH_W'(STACK_ENTRIES)))
		else $error("stack pushed beyond its capacity");

endmodule

FILE: design/nearest_smaller_max_difference.sv
// Streams in a sequence of positive 31-bit values, one per input beat, with last on the
// final beat, and after that beat returns one result beat: the largest absolute difference
// between each element's nearest strictly smaller neighbour on the left and on the right
// (zero where there is none), together with the number of elements kept and an overflow
// flag. Up to MAX_ITEMS (1024) elements are kept; further elements are dropped and set the
// flag, and a last beat among them still closes the sequence. Everything runs on one
// monotonic stack held in a single-port memory and one shared comparator, so the block
// takes one beat at a time and is not ready while it works. Loading an element takes the
// beat, then compare steps that pop the stack until the element can be pushed; each element
// is popped at most once. The backward pass after the last beat clears the stack, then per
// element loads it, pops and compares, and folds its difference into the maximum. The
// result sits in an output register, so a new sequence may begin loading while the previous
// result still waits to be taken. No clearing pass is needed after reset.
module nearest_smaller_max_difference (
	input  logic      clk,
	input  logic      arst_n,
	nsmd_in_if.sink   items,
	nsmd_out_if.source results
);
	import nsmd_pkg::*;

	// Element store and left-neighbour store, read together during the backward pass.
	value_t value_mem [MAX_ITEMS];
	value_t left_mem  [MAX_ITEMS];

	state_t      state_q, state_d;
	count_t      count_q, count_d;
	count_t      ridx_q, ridx_d;
	logic        ovf_q, ovf_d;
	logic        last_q, last_d;
	value_t      cur_q, cur_d;
	value_t      best_q, best_d;
	value_t      diff_q, diff_d;
	value_t      vrd_q;
	value_t      lrd_q;

	logic              out_valid_q, out_valid_d;
	value_t            out_diff_q;
	logic [ELEM_W-1:0] out_count_q;
	logic              out_ovf_q;
	logic              out_load;

	stk_cmd_t    stk_cmd;
	stk_status_t stk_st;

	logic   pop_need;
	logic   mem_we;
	logic   mem_re;
	addr_t  rd_addr;
	logic   in_take;

	nsmd_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.status (stk_st)
	);

	// The one shared comparator: pop while the top is not strictly smaller than the key.
	assign pop_need = !stk_st.at_base && (stk_st.top >= cur_q);

	assign items.ready = (state_q == ST_IDLE);
	assign in_take     = items.valid && items.ready;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ridx_d      = ridx_q;
		ovf_d       = ovf_q;
		last_d      = last_q;
		cur_d       = cur_q;
		best_d      = best_q;
		diff_d      = diff_q;
		stk_cmd.op   = STK_NOP;
		stk_cmd.data = cur_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		rd_addr     = ADDR_W'(count_q - CNT_W'(1));
		out_load    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					cur_d  = items.value;
					last_d = items.last;
					if (count_q < CNT_W'(MAX_ITEMS)) begin
						state_d = ST_LCMP;
					end else begin
						ovf_d = 1'b1;
						if (items.last) begin
							state_d = ST_RSTART;
						end
					end
				end
			end
			ST_LCMP: begin
				if (pop_need) begin
					stk_cmd.op = STK_POP;
				end else begin
					// The current top is this element's left neighbour.
					mem_we     = 1'b1;
					stk_cmd.op = STK_PUSH;
					count_d    = count_q + CNT_W'(1);
					state_d    = last_q ? ST_RSTART : ST_IDLE;
				end
			end
			ST_RSTART: begin
				stk_cmd.op = STK_CLEAR;
				best_d     = '0;
				ridx_d     = count_q;
				if (count_q == '0) begin
					state_d = ST_FIN;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_RLOAD;
				end
			end
			ST_RLOAD: begin
				cur_d   = vrd_q;
				state_d = ST_RCMP;
			end
			ST_RCMP: begin
				if (pop_need) begin
					stk_cmd.op = STK_POP;
				end else begin
					stk_cmd.op = STK_PUSH;
					diff_d  = (lrd_q >= stk_st.top) ? (lrd_q - stk_st.top)
						: (stk_st.top - lrd_q);
					state_d = ST_RMAX;
				end
			end
			ST_RMAX: begin
				if (diff_q > best_q) begin
					best_d = diff_q;
				end
				ridx_d = ridx_q - CNT_W'(1);
				if (ridx_q == CNT_W'(1)) begin
					state_d = ST_FIN;
				end else begin
					mem_re  = 1'b1;
					rd_addr = ADDR_W'(ridx_q - CNT_W'(2));
					state_d = ST_RLOAD;
				end
			end
			ST_FIN: begin
				// Wait only if an earlier result is still unclaimed.
				if (!out_valid_q || results.ready) begin
					out_load   = 1'b1;
					stk_cmd.op = STK_CLEAR;
					count_d    = '0;
					ovf_d      = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (results.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			value_mem[ADDR_W'(count_q)] <= cur_q;
			left_mem[ADDR_W'(count_q)]  <= stk_st.top;
		end
		if (mem_re) begin
			vrd_q <= value_mem[rd_addr];
			lrd_q <= left_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= ridx_d;
		last_q <= last_d;
		cur_q  <= cur_d;
		best_q <= best_d;
		diff_q <= diff_d;
		if (out_load) begin
			out_diff_q  <= best_q;
			out_count_q <= ELEM_W'(count_q);
			out_ovf_q   <= ovf_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.max_difference = out_diff_q;
	assign results.element_count  = out_count_q;
	assign results.overflow       = out_ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LCMP && !pop_need) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("stored element not counted");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMAX) |=> (best_q >= $past(diff_q)))
		else $error("running maximum lost a difference");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LCMP || state_q == ST_RCMP) |->
		(stk_st.depth <= DEPTH_W'(count_q) + DEPTH_W'(1)))
		else $error("stack deeper than the elements pushed");

endmodule
